// File: rtl/mbet_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time pixel core.
package mbet_pkg;

    // Coordinate format: signed, COORD_BITS wide with FRAC_BITS fraction bits.
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int PROD_BITS  = 2 * COORD_BITS;

    // Item field and register widths.
    localparam int ITER_BITS  = 16;
    localparam int COL_BITS   = 12;
    localparam int WIDTH_BITS = 13;
    localparam int INDEX_BITS = 24;

    // Column or row times step, with a zero sign bit in front of the index.
    localparam int MAP_BITS  = COORD_BITS + COL_BITS + 1;
    localparam int ROWW_BITS = COL_BITS + WIDTH_BITS;

    // Register map.
    localparam int REG_COUNT = 6;
    localparam int ADDR_BITS = $clog2(REG_COUNT * 4);
    localparam int RIDX_BITS = ADDR_BITS - 2;
    localparam int DATA_BITS = 32;

    localparam logic [RIDX_BITS-1:0] REG_ORIGIN_RE = RIDX_BITS'(0);
    localparam logic [RIDX_BITS-1:0] REG_ORIGIN_IM = RIDX_BITS'(1);
    localparam logic [RIDX_BITS-1:0] REG_STEP_RE   = RIDX_BITS'(2);
    localparam logic [RIDX_BITS-1:0] REG_STEP_IM   = RIDX_BITS'(3);
    localparam logic [RIDX_BITS-1:0] REG_WIDTH     = RIDX_BITS'(4);
    localparam logic [RIDX_BITS-1:0] REG_MAX_ITER  = RIDX_BITS'(5);

    // Register reset values.
    localparam logic [COORD_BITS-1:0] RST_ORIGIN_RE = 32'hE000_0000;
    localparam logic [COORD_BITS-1:0] RST_ORIGIN_IM = 32'hF000_0000;
    localparam logic [COORD_BITS-1:0] RST_STEP_RE   = 32'h0010_0000;
    localparam logic [COORD_BITS-1:0] RST_STEP_IM   = 32'h0010_0000;
    localparam logic [WIDTH_BITS-1:0] RST_WIDTH     = WIDTH_BITS'(640);
    localparam logic [ITER_BITS-1:0]  RST_MAX_ITER  = ITER_BITS'(256);

    // Escape bound: |z|^2 > 4, in the format of the exact squares.
    localparam logic [PROD_BITS-1:0] ESC_LIMIT = PROD_BITS'(4) << (2 * FRAC_BITS);

    // Saturation bounds, sign-extended to the product width.
    localparam logic signed [PROD_BITS-1:0] SAT_HI =
        {{(PROD_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [PROD_BITS-1:0] SAT_LO =
        {{(PROD_BITS - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_re;
        logic signed [COORD_BITS-1:0] origin_im;
        logic signed [COORD_BITS-1:0] step_re;
        logic signed [COORD_BITS-1:0] step_im;
        logic [WIDTH_BITS-1:0]        image_width;
        logic [ITER_BITS-1:0]         max_iterations;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic map_mul;
        logic map_add;
        logic it_mul;
        logic it_upd;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_max;
        logic escaped;
    } t_stat;

    // Clamp a wide signed value to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [PROD_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/mandelbrot_escape_time_pixel_core.sv
// Top level of the Mandelbrot escape-time pixel core.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_pixel_col, i_pixel_row
//  out      output     o_out_valid / i_out_ready  o_iteration_count, o_pixel_index
//  config   input      APB psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// An accepted item passes through two mapping states, then a multiply state and an update
// state per iteration through the three 32x32 multipliers. It stops at the limit in the
// multiply state, or in the update state after the multiply that finds an escape, and is
// then moved into the output register. The next item is accepted only after that;
// while the output register is still full, the finished item waits in the datapath.
// Reset is synchronous, active low.
module mandelbrot_escape_time_pixel_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mbet_pkg::COL_BITS-1:0]     i_pixel_col,
    input  logic [mbet_pkg::COL_BITS-1:0]     i_pixel_row,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mbet_pkg::ITER_BITS-1:0]    o_iteration_count,
    output logic [mbet_pkg::INDEX_BITS-1:0]   o_pixel_index,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbet_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [mbet_pkg::DATA_BITS-1:0]    pwdata,
    output logic [mbet_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready
);

    mbet_pkg::t_cfg  w_cfg;
    mbet_pkg::t_cmd  w_cmd;
    mbet_pkg::t_stat w_stat;

    // Configuration registers.
    mbet_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    mbet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Arithmetic.
    mbet_dpath u_dpath (
        .i_clk             (i_clk),
        .i_cfg             (w_cfg),
        .i_cmd             (w_cmd),
        .i_pixel_col       (i_pixel_col),
        .i_pixel_row       (i_pixel_row),
        .o_stat            (w_stat),
        .o_iteration_count (o_iteration_count),
        .o_pixel_index     (o_pixel_index)
    );

endmodule

// File: rtl/mbet_regs.sv
// APB configuration register file of the Mandelbrot escape-time pixel core.
module mbet_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbet_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [mbet_pkg::DATA_BITS-1:0]   pwdata,
    output logic [mbet_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    output mbet_pkg::t_cfg                   o_cfg
);

    mbet_pkg::t_cfg                     r_cfg;
    logic [mbet_pkg::RIDX_BITS-1:0]     w_idx;
    logic                               w_wr;

    assign w_idx  = paddr[mbet_pkg::ADDR_BITS-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_re      <= mbet_pkg::RST_ORIGIN_RE;
            r_cfg.origin_im      <= mbet_pkg::RST_ORIGIN_IM;
            r_cfg.step_re        <= mbet_pkg::RST_STEP_RE;
            r_cfg.step_im        <= mbet_pkg::RST_STEP_IM;
            r_cfg.image_width    <= mbet_pkg::RST_WIDTH;
            r_cfg.max_iterations <= mbet_pkg::RST_MAX_ITER;
        end else if (w_wr) begin
            case (w_idx)
                mbet_pkg::REG_ORIGIN_RE: r_cfg.origin_re <= pwdata[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_ORIGIN_IM: r_cfg.origin_im <= pwdata[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_STEP_RE:   r_cfg.step_re   <= pwdata[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_STEP_IM:   r_cfg.step_im   <= pwdata[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_WIDTH: begin
                    r_cfg.image_width <= pwdata[mbet_pkg::WIDTH_BITS-1:0];
                end
                mbet_pkg::REG_MAX_ITER: begin
                    r_cfg.max_iterations <= pwdata[mbet_pkg::ITER_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data for the addressed register.
    always_comb begin
        case (w_idx)
            mbet_pkg::REG_ORIGIN_RE: prdata = mbet_pkg::DATA_BITS'(r_cfg.origin_re);
            mbet_pkg::REG_ORIGIN_IM: prdata = mbet_pkg::DATA_BITS'(r_cfg.origin_im);
            mbet_pkg::REG_STEP_RE:   prdata = mbet_pkg::DATA_BITS'(r_cfg.step_re);
            mbet_pkg::REG_STEP_IM:   prdata = mbet_pkg::DATA_BITS'(r_cfg.step_im);
            mbet_pkg::REG_WIDTH:     prdata = mbet_pkg::DATA_BITS'(r_cfg.image_width);
            mbet_pkg::REG_MAX_ITER:  prdata = mbet_pkg::DATA_BITS'(r_cfg.max_iterations);
            default:                 prdata = '0;
        endcase
    end

endmodule

// File: rtl/mbet_ctrl.sv
// Sequencing state machine of the Mandelbrot escape-time pixel core.
module mbet_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  mbet_pkg::t_stat i_stat,
    output mbet_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP1,
        S_MAP2,
        S_MUL,
        S_UPD,
        S_HOLD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        w_finish    = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAP1;
                end
            end
            S_MAP1: begin
                o_cmd.map_mul = 1'b1;
                n_state       = S_MAP2;
            end
            S_MAP2: begin
                o_cmd.map_add = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                if (i_stat.at_max) begin
                    w_finish = 1'b1;
                end else begin
                    o_cmd.it_mul = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                if (i_stat.escaped) begin
                    w_finish = 1'b1;
                end else begin
                    o_cmd.it_upd = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_HOLD: begin
                w_finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished item moves to the output register once it is free.
        if (w_finish) begin
            if (w_out_free) begin
                o_cmd.emit  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/mbet_dpath.sv
// Coordinate mapping, iteration and result datapath of the Mandelbrot pixel core.
module mbet_dpath (
    input  logic                              i_clk,
    input  mbet_pkg::t_cfg                    i_cfg,
    input  mbet_pkg::t_cmd                    i_cmd,
    input  logic [mbet_pkg::COL_BITS-1:0]     i_pixel_col,
    input  logic [mbet_pkg::COL_BITS-1:0]     i_pixel_row,
    output mbet_pkg::t_stat                   o_stat,
    output logic [mbet_pkg::ITER_BITS-1:0]    o_iteration_count,
    output logic [mbet_pkg::INDEX_BITS-1:0]   o_pixel_index
);

    localparam int CB = mbet_pkg::COORD_BITS;
    localparam int PB = mbet_pkg::PROD_BITS;
    localparam int MB = mbet_pkg::MAP_BITS;
    localparam int RB = mbet_pkg::ROWW_BITS;
    localparam int IB = mbet_pkg::INDEX_BITS;
    localparam int NB = mbet_pkg::ITER_BITS;
    localparam int FB = mbet_pkg::FRAC_BITS;

    logic [mbet_pkg::COL_BITS-1:0] r_col, r_row;
    logic signed [MB-1:0]          r_map_re, r_map_im;
    logic [RB-1:0]                 r_map_idx;
    logic signed [CB-1:0]          r_c_re, r_c_im, r_z_re, r_z_im;
    logic [IB-1:0]                 r_idx;
    logic [NB-1:0]                 r_iter;
    logic signed [PB-1:0]          r_sq_re, r_sq_im, r_cross;
    logic [NB-1:0]                 r_out_iter;
    logic [IB-1:0]                 r_out_idx;

    logic signed [MB-1:0]          w_map_re, w_map_im;
    logic [RB-1:0]                 w_map_idx;
    logic signed [PB-1:0]          w_sum_re, w_sum_im;
    logic [RB-1:0]                 w_idx_sum;
    logic signed [PB-1:0]          w_sq_re, w_sq_im, w_cross;
    logic [PB-1:0]                 w_mag;
    logic signed [PB-1:0]          w_diff, w_nre, w_nim;

    // Pixel to complex point: index times step, one multiplier per axis.
    assign w_map_re  = $signed({1'b0, r_col}) * $signed(i_cfg.step_re);
    assign w_map_im  = $signed({1'b0, r_row}) * $signed(i_cfg.step_im);
    assign w_map_idx = RB'(r_row) * RB'(i_cfg.image_width);

    // Origin offset in the following cycle.
    assign w_sum_re  = PB'(r_map_re) + PB'($signed(i_cfg.origin_re));
    assign w_sum_im  = PB'(r_map_im) + PB'($signed(i_cfg.origin_im));
    assign w_idx_sum = r_map_idx + RB'(r_col);

    // Exact squares and cross product of the current z.
    assign w_sq_re = PB'(r_z_re) * PB'(r_z_re);
    assign w_sq_im = PB'(r_z_im) * PB'(r_z_im);
    assign w_cross = PB'(r_z_re) * PB'(r_z_im);

    // Escape test and next z; arithmetic shifts round toward minus infinity.
    assign w_mag  = $unsigned(r_sq_re) + $unsigned(r_sq_im);
    assign w_diff = r_sq_re - r_sq_im;
    assign w_nre  = (w_diff >>> FB) + PB'(r_c_re);
    assign w_nim  = (r_cross >>> (FB - 1)) + PB'(r_c_im);

    assign o_stat.at_max  = (r_iter == i_cfg.max_iterations);
    assign o_stat.escaped = (w_mag > mbet_pkg::ESC_LIMIT);

    assign o_iteration_count = r_out_iter;
    assign o_pixel_index     = r_out_idx;

    // Datapath registers, each loaded by its command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= i_pixel_col;
            r_row <= i_pixel_row;
        end
        if (i_cmd.map_mul) begin
            r_map_re  <= w_map_re;
            r_map_im  <= w_map_im;
            r_map_idx <= w_map_idx;
        end
        if (i_cmd.map_add) begin
            r_c_re <= mbet_pkg::sat_coord(w_sum_re);
            r_c_im <= mbet_pkg::sat_coord(w_sum_im);
            r_z_re <= mbet_pkg::sat_coord(w_sum_re);
            r_z_im <= mbet_pkg::sat_coord(w_sum_im);
            r_idx  <= w_idx_sum[IB-1:0];
            r_iter <= '0;
        end
        if (i_cmd.it_mul) begin
            r_sq_re <= w_sq_re;
            r_sq_im <= w_sq_im;
            r_cross <= w_cross;
        end
        if (i_cmd.it_upd) begin
            r_z_re <= mbet_pkg::sat_coord(w_nre);
            r_z_im <= mbet_pkg::sat_coord(w_nim);
            r_iter <= r_iter + NB'(1);
        end
        if (i_cmd.emit) begin
            r_out_iter <= r_iter;
            r_out_idx  <= r_idx;
        end
    end

endmodule

// File: rtl/mbet_checker.sv
// Port-level assertions for the Mandelbrot escape-time pixel core, with its bind.
module mbet_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [mbet_pkg::ITER_BITS-1:0]    o_iteration_count,
    input logic [mbet_pkg::INDEX_BITS-1:0]   o_pixel_index
);

    // After an item is accepted, the core is not ready in the next cycle.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("input ready right after an item was accepted");

    // No result can appear in the cycle right after an item is accepted.
    a_no_instant_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid)
    ) else $error("result appeared one cycle after acceptance");

    // A result only appears while an item was in work.
    a_result_from_work: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready)
    ) else $error("result appeared while the core was idle");

    // A stalled result holds its value.
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_iteration_count) && $stable(o_pixel_index))
    ) else $error("stalled result changed or was dropped");

endmodule

bind mandelbrot_escape_time_pixel_core mbet_checker u_mbet_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_iteration_count (o_iteration_count),
    .o_pixel_index     (o_pixel_index)
);

// File: tb/mandelbrot_escape_time_pixel_core_test.sv
// Self-checking testbench for the Mandelbrot escape-time pixel core, with a predicting scoreboard.
module mandelbrot_escape_time_pixel_core_test;

    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int          SETTINGS_CNT = 7;
    localparam int unsigned HOLD_AFTER   = 30;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int          TAIL_CYCLES  = 16;

    // Register indexes that decode to no register.
    localparam logic [mbet_pkg::RIDX_BITS-1:0] REG_UNMAPPED_A = mbet_pkg::RIDX_BITS'(6);
    localparam logic [mbet_pkg::RIDX_BITS-1:0] REG_UNMAPPED_B = mbet_pkg::RIDX_BITS'(7);

    localparam longint          COORD_HI     = 64'sd2147483647;
    localparam longint          COORD_LO     = -64'sd2147483648;
    localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * mbet_pkg::FRAC_BITS);

    typedef struct {
        logic [mbet_pkg::ITER_BITS-1:0]  count;
        logic [mbet_pkg::INDEX_BITS-1:0] pix_index;
    } t_pixel_result;

    // Scoreboard: shadow registers, escape-time predictor and the queue of expected results.
    class escape_scoreboard;
        mbet_pkg::t_cfg regs;
        t_pixel_result  pending_results[$];
        int unsigned    pixels_noted;
        int unsigned    results_checked;
        int unsigned    mismatches;

        function void reset_regs();
            regs.origin_re      = mbet_pkg::RST_ORIGIN_RE;
            regs.origin_im      = mbet_pkg::RST_ORIGIN_IM;
            regs.step_re        = mbet_pkg::RST_STEP_RE;
            regs.step_im        = mbet_pkg::RST_STEP_IM;
            regs.image_width    = mbet_pkg::RST_WIDTH;
            regs.max_iterations = mbet_pkg::RST_MAX_ITER;
        endfunction

        function void write_reg(logic [mbet_pkg::RIDX_BITS-1:0] idx,
                                logic [mbet_pkg::DATA_BITS-1:0] value);
            case (idx)
                mbet_pkg::REG_ORIGIN_RE: regs.origin_re = value[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_ORIGIN_IM: regs.origin_im = value[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_STEP_RE:   regs.step_re   = value[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_STEP_IM:   regs.step_im   = value[mbet_pkg::COORD_BITS-1:0];
                mbet_pkg::REG_WIDTH:     regs.image_width = value[mbet_pkg::WIDTH_BITS-1:0];
                mbet_pkg::REG_MAX_ITER:  regs.max_iterations = value[mbet_pkg::ITER_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_HI) begin
                return COORD_HI;
            end
            if (v < COORD_LO) begin
                return COORD_LO;
            end
            return v;
        endfunction

        // Iterate z = z^2 + c from z = c and count the iterations before |z|^2 exceeds 4 or the limit is reached.
        function logic [mbet_pkg::ITER_BITS-1:0] escape_count(
            logic [mbet_pkg::COL_BITS-1:0] col,
            logic [mbet_pkg::COL_BITS-1:0] row
        );
            longint          c_re, c_im, z_re, z_im, mag_re, mag_im, next_re, next_im;
            longint unsigned sq_re, sq_im;
            int unsigned     limit, i;
            c_re = clamp_coord(longint'($signed(regs.origin_re)) +
                               longint'(col) * longint'($signed(regs.step_re)));
            c_im = clamp_coord(longint'($signed(regs.origin_im)) +
                               longint'(row) * longint'($signed(regs.step_im)));
            z_re  = c_re;
            z_im  = c_im;
            limit = regs.max_iterations;
            for (i = 0; i < limit; i++) begin
                mag_re = (z_re < 0) ? -z_re : z_re;
                mag_im = (z_im < 0) ? -z_im : z_im;
                sq_re  = mag_re * mag_re;
                sq_im  = mag_im * mag_im;
                if (sq_re + sq_im > ESCAPE_BOUND) begin
                    break;
                end
                // Both shifts round toward minus infinity; the cross term is doubled.
                next_re = (longint'(sq_re) - longint'(sq_im)) >>> mbet_pkg::FRAC_BITS;
                next_im = (z_re * z_im) >>> (mbet_pkg::FRAC_BITS - 1);
                z_re    = clamp_coord(next_re + c_re);
                z_im    = clamp_coord(next_im + c_im);
            end
            return i[mbet_pkg::ITER_BITS-1:0];
        endfunction

        function void note_pixel(logic [mbet_pkg::COL_BITS-1:0] col,
                                 logic [mbet_pkg::COL_BITS-1:0] row);
            t_pixel_result want;
            longint        lin;
            lin            = longint'(row) * longint'(regs.image_width) + longint'(col);
            want.count     = escape_count(col, row);
            want.pix_index = lin[mbet_pkg::INDEX_BITS-1:0];
            pending_results.push_back(want);
            pixels_noted++;
        endfunction

        function void check_result(logic [mbet_pkg::ITER_BITS-1:0] count,
                                   logic [mbet_pkg::INDEX_BITS-1:0] pix);
            t_pixel_result want;
            results_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, count %0d index %0d",
                         $time, count, pix);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (count !== want.count) begin
                $display("%0t: iteration_count expected %0d, actual %0d (index %0d)",
                         $time, want.count, count, want.pix_index);
                mismatches++;
            end
            if (pix !== want.pix_index) begin
                $display("%0t: pixel_index expected %0d, actual %0d",
                         $time, want.pix_index, pix);
                mismatches++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n           = 1'b0;
    logic                             i_in_valid        = 1'b0;
    logic                             o_in_ready;
    logic [mbet_pkg::COL_BITS-1:0]    i_pixel_col       = '0;
    logic [mbet_pkg::COL_BITS-1:0]    i_pixel_row       = '0;
    logic                             o_out_valid;
    logic                             i_out_ready       = 1'b0;
    logic [mbet_pkg::ITER_BITS-1:0]   o_iteration_count;
    logic [mbet_pkg::INDEX_BITS-1:0]  o_pixel_index;
    logic                             psel              = 1'b0;
    logic                             penable           = 1'b0;
    logic                             pwrite            = 1'b0;
    logic [mbet_pkg::ADDR_BITS-1:0]   paddr             = '0;
    logic [mbet_pkg::DATA_BITS-1:0]   pwdata            = '0;
    logic [mbet_pkg::DATA_BITS-1:0]   prdata;
    logic                             pready;

    escape_scoreboard sb = new;
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      col_hi         = 4095;
    int unsigned      row_hi         = 4095;
    int unsigned      cycles         = 0;

    mandelbrot_escape_time_pixel_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_pixel_col       (i_pixel_col),
        .i_pixel_row       (i_pixel_row),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_iteration_count (o_iteration_count),
        .o_pixel_index     (o_pixel_index),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: check each accepted item, stall at random and hold off once for a long time.
    initial begin : result_drain
        int unsigned hold_left;
        bit          held_off;
        hold_left = 0;
        held_off  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_iteration_count, o_pixel_index);
            end
            if (!held_off && sb.results_checked == HOLD_AFTER) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One register write: setup cycle and access cycle, then the bus is released.
    task automatic apb_write(input logic [mbet_pkg::RIDX_BITS-1:0] idx,
                             input logic [mbet_pkg::DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [mbet_pkg::DATA_BITS-1:0] ore,
                                  input logic [mbet_pkg::DATA_BITS-1:0] oim,
                                  input logic [mbet_pkg::DATA_BITS-1:0] sre,
                                  input logic [mbet_pkg::DATA_BITS-1:0] sim,
                                  input logic [mbet_pkg::DATA_BITS-1:0] wid,
                                  input logic [mbet_pkg::DATA_BITS-1:0] mit);
        apb_write(mbet_pkg::REG_ORIGIN_RE, ore);
        apb_write(mbet_pkg::REG_ORIGIN_IM, oim);
        apb_write(mbet_pkg::REG_STEP_RE, sre);
        apb_write(mbet_pkg::REG_STEP_IM, sim);
        apb_write(mbet_pkg::REG_WIDTH, wid);
        apb_write(mbet_pkg::REG_MAX_ITER, mit);
    endtask

    // Offer one pixel after an optional random gap, and hold it until it is accepted.
    task automatic send_pixel(input logic [mbet_pkg::COL_BITS-1:0] col,
                              input logic [mbet_pkg::COL_BITS-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(col, row);
    endtask

    // Mostly pixels inside the interesting window, some anywhere in the field range.
    task automatic send_random_pixel();
        logic [mbet_pkg::COL_BITS-1:0] col, row;
        if ($urandom_range(3) != 0) begin
            col = mbet_pkg::COL_BITS'($urandom_range(col_hi));
            row = mbet_pkg::COL_BITS'($urandom_range(row_hi));
        end else begin
            col = mbet_pkg::COL_BITS'($urandom);
            row = mbet_pkg::COL_BITS'($urandom);
        end
        send_pixel(col, row);
    endtask

    task automatic wait_for_results();
        while (sb.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register setting, pixel window and directed pixels of each part of the run.
    task automatic run_setting(input int s);
        logic [mbet_pkg::DATA_BITS-1:0] garbage;
        garbage = $urandom;
        case (s)
            0: begin
                // Reset values: the classic view, limit 256.
                col_hi = 767;
                row_hi = 511;
                send_pixel(12'd0, 12'd0);
                send_pixel(12'd4095, 12'd4095);
                send_pixel(12'd4095, 12'd0);
                send_pixel(12'd0, 12'd4095);
                send_pixel(12'hAAA, 12'h555);
                send_pixel(12'h555, 12'hAAA);
                send_pixel(12'd512, 12'd256);   // c = 0, never escapes
                send_pixel(12'd448, 12'd256);   // c = -0.25, inside
                send_pixel(12'd0, 12'd256);     // c = -2 sits on the escape bound for good
                send_pixel(12'd767, 12'd511);
                send_pixel(12'd1, 12'd1);
                send_pixel(12'd416, 12'd448);
            end
            1: begin
                // Width of one, coarser grid, limit 64.
                write_all_regs(32'hE000_0000, 32'hEC00_0000, 32'h0020_0000, 32'h0020_0000,
                               32'd1, 32'd64);
                col_hi = 383;
                row_hi = 319;
            end
            2: begin
                // Zero iteration limit and saturating coordinate extremes.
                write_all_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'd4096, 32'd0);
                col_hi = 4095;
                row_hi = 4095;
                send_pixel(12'd4095, 12'd4095);
                send_pixel(12'd0, 12'd0);
                send_pixel(12'd4095, 12'd0);
                send_pixel(12'd0, 12'd4095);
            end
            3: begin
                // Largest limit, but every point lies right of the set and escapes fast.
                // Width beyond the pixel range makes the linear index wrap.
                write_all_regs(32'h1000_0000, 32'h0800_0000, 32'h0010_0000, 32'h0010_0000,
                               32'd8191, 32'd65535);
                col_hi = 4095;
                row_hi = 4095;
                send_pixel(12'd4095, 12'd4095);
                send_pixel(12'd0, 12'd0);
                send_pixel(12'd4095, 12'd0);
            end
            4: begin
                // Zero width, negative steps, writes to unmapped registers.
                write_all_regs(32'h0800_0000, 32'h1400_0000, 32'hFFF8_0000, 32'hFFF8_0000,
                               32'd0, 32'd100);
                apb_write(REG_UNMAPPED_A, garbage);
                apb_write(REG_UNMAPPED_B, ~garbage);
                col_hi = 1279;
                row_hi = 1279;
                send_pixel(12'd0, 12'd0);
                send_pixel(12'd4095, 12'd4095);
            end
            5: begin
                // Random view of the set, with junk in the unused upper register bits.
                write_all_regs($urandom_range(805306368) - 32'd671088640,
                               $urandom_range(402653184) - 32'd402653184,
                               $urandom_range(32'h0010_0000, 32'h0002_0000),
                               $urandom_range(32'h0010_0000, 32'h0002_0000),
                               (garbage & ~32'h1FFF) | $urandom_range(4096, 1),
                               (~garbage & ~32'hFFFF) | $urandom_range(200, 1));
                col_hi = 767;
                row_hi = 767;
            end
            default: begin
                // Fully random coordinates with a very small limit.
                write_all_regs($urandom, $urandom, $urandom, $urandom,
                               $urandom_range(8191), $urandom_range(8, 1));
                col_hi = 4095;
                row_hi = 4095;
            end
        endcase
    endtask

    task automatic apply_idling(input int s);
        case (s % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    // Stimulus: reset, then each register setting with random pixels and, for some settings, directed ones.
    initial begin : stimulus
        int random_items[SETTINGS_CNT];
        int s, k;
        random_items = '{260, 280, 240, 60, 280, 280, 240};
        sb.reset_regs();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (s = 0; s < SETTINGS_CNT; s++) begin
            wait_for_results();
            apply_idling(s);
            run_setting(s);
            for (k = 0; k < random_items[s]; k++) begin
                send_random_pixel();
            end
            i_in_valid <= 1'b0;
        end
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d pixels over %0d register settings in %0d cycles.",
                 sb.results_checked, sb.pixels_noted, SETTINGS_CNT, cycles);
        $display("Limits from 0 to 65535, widths 0 to 8191, saturated coordinates, %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
